// ----- hdl/rmq_pkg.sv -----
`default_nettype none

package rmq_pkg;

    // Matrix and quaternion fields are signed fixed point
    localparam int FRAC_BITS = 16;
    localparam int D_W       = 18;
    localparam int N_IN      = 9;
    localparam int N_OUT     = 4;

    // Square-root argument: up to 3 * max entry + one, positive part
    localparam int A_W    = D_W + 3;
    localparam int ARG_W  = A_W - 1;
    localparam int RAD_W  = ARG_W + FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // Numerators are sums or differences of two entries
    localparam int NUM_W = D_W + 1;
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int DEN_W = ROOT_W + 1;
    // Smallest positive argument gives a root of sqrt(2^FRAC_BITS), so the
    // divisor is at least 2^(FRAC_BITS/2 + 1) and the quotient stays below
    // 2^(DVD_W - FRAC_BITS/2 - 1)
    localparam int Q_W   = DVD_W - FRAC_BITS / 2 - 1;

    localparam int STAGES = 1 + ROOT_W + Q_W;

    localparam int IN_TDATA_W  = ((N_IN * D_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((N_OUT * D_W + 7) / 8) * 8;

    localparam logic signed [D_W-1:0] OUT_MAX = {1'b0, {(D_W-1){1'b1}}};
    localparam logic signed [D_W-1:0] OUT_MIN = {1'b1, {(D_W-1){1'b0}}};

    // Output slot codes
    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    // Sideband that travels beside the square root
    typedef struct packed {
        logic [N_OUT-1:0][NUM_W-1:0] num;
        logic [1:0]                  big;
        logic                        deg;
    } side_sqrt_t;

    // Sideband that travels beside the dividers
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [N_OUT-1:0]  neg;
        logic [1:0]        big;
        logic              deg;
    } side_div_t;

    // Apply sign to a quotient magnitude and clamp to the field range
    function automatic logic [D_W-1:0] sat_mag(input logic neg, input logic [Q_W-1:0] mag);
        logic [Q_W-1:0] neg_mag;
        logic [D_W-1:0] res;
        neg_mag = -mag;
        if (neg) begin
            if (mag > Q_W'(2 ** (D_W - 1))) begin
                res = OUT_MIN;
            end
            else begin
                res = neg_mag[D_W-1:0];
            end
        end
        else begin
            if (mag > Q_W'(2 ** (D_W - 1) - 1)) begin
                res = OUT_MAX;
            end
            else begin
                res = mag[D_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rmq_isqrt.sv -----
`default_nettype none

// Pipelined restoring integer square root, one result bit per stage
module rmq_isqrt
    import rmq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [RAD_W-1:0]  rad,
    output logic      [ROOT_W-1:0] root
);

    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [RAD_W-1:0]  rad_next  [ROOT_W];

    // Each stage brings down two radicand bits and tries one root bit
    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        for (int s = 0; s < ROOT_W; s++) begin
            if (s == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = rad;
            end
            else begin
                rem_in  = rem_reg[s-1];
                root_in = root_reg[s-1];
                rad_in  = rad_reg[s-1];
            end
            rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial  = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next[s]  = REM_W'(rem_sh - trial);
                root_next[s] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else begin
                rem_next[s]  = rem_sh[REM_W-1:0];
                root_next[s] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[s] = {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int s = 0; s < ROOT_W; s++) begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- hdl/rmq_div.sv -----
`default_nettype none

// Pipelined restoring unsigned divider, one quotient bit per stage
module rmq_div
    import rmq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DVD_W-1:0] dvd,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quot
);

    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   quot_reg  [Q_W];
    logic [Q_W-1:0]   lo_reg    [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    logic [DEN_W-1:0] rem_next  [Q_W];
    logic [Q_W-1:0]   quot_next [Q_W];
    logic [Q_W-1:0]   lo_next   [Q_W];
    logic [DEN_W-1:0] den_next  [Q_W];

    // Shift in one dividend bit, subtract the divisor where it fits
    always_comb
    begin
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   quot_in;
        logic [Q_W-1:0]   lo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   rem_sh;
        for (int s = 0; s < Q_W; s++) begin
            if (s == 0) begin
                rem_in  = DEN_W'(dvd[DVD_W-1:Q_W]);
                quot_in = '0;
                lo_in   = dvd[Q_W-1:0];
                den_in  = den;
            end
            else begin
                rem_in  = rem_reg[s-1];
                quot_in = quot_reg[s-1];
                lo_in   = lo_reg[s-1];
                den_in  = den_reg[s-1];
            end
            rem_sh = {rem_in, lo_in[Q_W-1]};
            if (rem_sh >= {1'b0, den_in}) begin
                rem_next[s]  = DEN_W'(rem_sh - {1'b0, den_in});
                quot_next[s] = {quot_in[Q_W-2:0], 1'b1};
            end
            else begin
                rem_next[s]  = rem_sh[DEN_W-1:0];
                quot_next[s] = {quot_in[Q_W-2:0], 1'b0};
            end
            lo_next[s]  = {lo_in[Q_W-2:0], 1'b0};
            den_next[s] = den_in;
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int s = 0; s < Q_W; s++) begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                lo_reg[s]   <= lo_next[s];
                den_reg[s]  <= den_next[s];
            end
        end
    end

    assign quot = quot_reg[Q_W-1];

endmodule

`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion_core.sv -----
`default_nettype none

// Converts a 3x3 rotation matrix (signed Q2.16) to a unit quaternion by
// Shepperd's method. One transfer is taken every cycle while the skid entry
// is empty; each item passes 1 setup stage, 18 square-root stages and 26
// divider stages, then the output register. A one-entry skid buffer behind
// the output register keeps input transfers flowing while a result waits
// until it fills. Results whose square-root argument is not positive come
// out as zero with the degenerate flag set in tuser; other components saturate.
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (18 bits each), zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // qx, qy, qz, qw (18 bits each)
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // degenerate
    output logic [0:0]                  m_axis_tuser
);

    logic                    en;
    logic [STAGES-1:0]       vld_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [RAD_W-1:0]        rad_next;
    side_sqrt_t              side1_reg;
    side_sqrt_t              side1_next;
    side_sqrt_t              sq_side_reg [ROOT_W];
    side_div_t               dv_side_reg [Q_W];
    side_div_t               dv_side_next;
    logic [ROOT_W-1:0]       root;
    logic [N_OUT-1:0][DVD_W-1:0] dvd;
    logic [N_OUT-1:0][Q_W-1:0]   quot;
    logic [OUT_TDATA_W-1:0]  p_data;
    logic                    p_deg;
    logic                    p_take;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    out_deg_reg;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  skid_data_reg;
    logic                    skid_deg_reg;
    logic                    skid_valid_reg;
    logic                    out_load;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // Setup stage: trace, branch, square-root argument and numerators
    always_comb
    begin
        logic signed [D_W-1:0] r [N_IN];
        logic signed [A_W-1:0] trace;
        logic signed [A_W-1:0] rii;
        logic signed [A_W-1:0] rjj;
        logic signed [A_W-1:0] rkk;
        logic signed [A_W-1:0] arg;
        logic signed [A_W-1:0] one;
        logic [1:0]            i;
        logic                  pos;
        for (int f = 0; f < N_IN; f++) begin
            r[f] = s_axis_tdata[f*D_W +: D_W];
        end
        one   = A_W'(2 ** FRAC_BITS);
        trace = A_W'(r[0]) + A_W'(r[4]) + A_W'(r[8]);
        pos   = trace > 0;
        if (r[0] < r[4]) begin
            i = (r[4] < r[8]) ? SLOT_Z : SLOT_Y;
        end
        else begin
            i = (r[0] < r[8]) ? SLOT_Z : SLOT_X;
        end
        unique case (i)
            SLOT_X:
            begin
                rii = A_W'(r[0]);
                rjj = A_W'(r[4]);
                rkk = A_W'(r[8]);
            end
            SLOT_Y:
            begin
                rii = A_W'(r[4]);
                rjj = A_W'(r[8]);
                rkk = A_W'(r[0]);
            end
            default:
            begin
                rii = A_W'(r[8]);
                rjj = A_W'(r[0]);
                rkk = A_W'(r[4]);
            end
        endcase
        arg = pos ? (trace + one) : (rii - rjj - rkk + one);
        side1_next.deg = !pos && (arg <= 0);
        rad_next = side1_next.deg ? '0 : {arg[ARG_W-1:0], {FRAC_BITS{1'b0}}};
        side1_next.big = pos ? SLOT_W : i;
        // Numerators per output slot; the large slot's entry is unused
        if (pos) begin
            side1_next.num[SLOT_X] = NUM_W'(r[7]) - NUM_W'(r[5]);
            side1_next.num[SLOT_Y] = NUM_W'(r[2]) - NUM_W'(r[6]);
            side1_next.num[SLOT_Z] = NUM_W'(r[3]) - NUM_W'(r[1]);
            side1_next.num[SLOT_W] = '0;
        end
        else begin
            unique case (i)
                SLOT_X:
                begin
                    side1_next.num[SLOT_X] = '0;
                    side1_next.num[SLOT_Y] = NUM_W'(r[3]) + NUM_W'(r[1]);
                    side1_next.num[SLOT_Z] = NUM_W'(r[6]) + NUM_W'(r[2]);
                    side1_next.num[SLOT_W] = NUM_W'(r[7]) - NUM_W'(r[5]);
                end
                SLOT_Y:
                begin
                    side1_next.num[SLOT_X] = NUM_W'(r[1]) + NUM_W'(r[3]);
                    side1_next.num[SLOT_Y] = '0;
                    side1_next.num[SLOT_Z] = NUM_W'(r[7]) + NUM_W'(r[5]);
                    side1_next.num[SLOT_W] = NUM_W'(r[2]) - NUM_W'(r[6]);
                end
                default:
                begin
                    side1_next.num[SLOT_X] = NUM_W'(r[2]) + NUM_W'(r[6]);
                    side1_next.num[SLOT_Y] = NUM_W'(r[5]) + NUM_W'(r[7]);
                    side1_next.num[SLOT_Z] = '0;
                    side1_next.num[SLOT_W] = NUM_W'(r[3]) - NUM_W'(r[1]);
                end
            endcase
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_axis_tvalid};
        end
    end

    // Setup register and sideband delay beside the square root
    always_ff @(posedge clk)
    begin
        if (en) begin
            rad_reg        <= rad_next;
            side1_reg      <= side1_next;
            sq_side_reg[0] <= side1_reg;
            for (int s = 1; s < ROOT_W; s++) begin
                sq_side_reg[s] <= sq_side_reg[s-1];
            end
        end
    end

    rmq_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    // Divider operands: magnitude of each numerator scaled by one, over 2h
    always_comb
    begin
        logic signed [NUM_W-1:0] n;
        logic        [NUM_W-1:0] mag;
        for (int l = 0; l < N_OUT; l++) begin
            n   = sq_side_reg[ROOT_W-1].num[l];
            mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
            dvd[l] = {mag, {FRAC_BITS{1'b0}}};
            dv_side_next.neg[l] = n[NUM_W-1];
        end
        dv_side_next.root = root;
        dv_side_next.big  = sq_side_reg[ROOT_W-1].big;
        dv_side_next.deg  = sq_side_reg[ROOT_W-1].deg;
    end

    for (genvar l = 0; l < N_OUT; l++) begin : g_lane
        rmq_div u_div (
            .clk  (clk),
            .en   (en),
            .dvd  (dvd[l]),
            .den  ({root, 1'b0}),
            .quot (quot[l])
        );
    end

    // Sideband delay beside the dividers
    always_ff @(posedge clk)
    begin
        if (en) begin
            dv_side_reg[0] <= dv_side_next;
            for (int s = 1; s < Q_W; s++) begin
                dv_side_reg[s] <= dv_side_reg[s-1];
            end
        end
    end

    // Assemble the result: all zero if degenerate, else large slot from the root, others from quotients
    always_comb
    begin
        side_div_t        sd;
        logic [D_W-1:0]   comp;
        sd = dv_side_reg[Q_W-1];
        for (int l = 0; l < N_OUT; l++) begin
            if (sd.deg) begin
                comp = '0;
            end
            else if (sd.big == 2'(l)) begin
                comp = D_W'(sd.root >> 1);
            end
            else begin
                comp = sat_mag(sd.neg[l], quot[l]);
            end
            p_data[l*D_W +: D_W] = comp;
        end
        p_deg = sd.deg;
    end

    assign p_take   = en && vld_reg[STAGES-1];
    assign out_load = !out_valid_reg || m_axis_tready;

    // Output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load) begin
            out_valid_reg  <= skid_valid_reg || p_take;
            skid_valid_reg <= 1'b0;
        end
        else if (p_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : p_data;
            out_deg_reg  <= skid_valid_reg ? skid_deg_reg : p_deg;
        end
        else if (p_take) begin
            skid_data_reg <= p_data;
            skid_deg_reg  <= p_deg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_deg_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output result");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid entry filled while output was free");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_deg_reg) |-> (out_data_reg == '0))
        else $error("degenerate result carries nonzero components");
`endif

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    typedef logic signed [D_W-1:0] fix_t;

    typedef struct {
        fix_t q[4];
        logic deg;
    } quat_t;

    // Tracks expected quaternions in the order their matrices were accepted
    class quat_scoreboard;
        quat_t pending[$];
        int    errors;
        int    matrices;
        int    results;
        int    degen_seen;
        int    trace_seen;

        static function automatic longint root_floor(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        static function automatic fix_t clamp(longint v);
            if (v > 131071) return 18'sd131071;
            if (v < -131072) return -18'sd131072;
            return fix_t'(v);
        endfunction

        // Work out the quaternion for one accepted matrix
        function automatic void note_matrix(fix_t m[3][3]);
            quat_t  e;
            longint one;
            longint tr;
            longint arg;
            longint h;
            longint h2;
            longint qv[4];
            int     i;
            int     j;
            int     k;
            one = 64'sd1 <<< FRAC_BITS;
            for (int n = 0; n < 4; n++) qv[n] = 0;
            e.deg = 1'b0;
            tr = longint'(m[0][0]) + longint'(m[1][1]) + longint'(m[2][2]);
            if (tr > 0)
            begin
                trace_seen++;
                h = root_floor((tr + one) <<< FRAC_BITS);
                h2 = h * 2;
                qv[3] = h >>> 1;
                qv[0] = ((longint'(m[2][1]) - m[1][2]) * one) / h2;
                qv[1] = ((longint'(m[0][2]) - m[2][0]) * one) / h2;
                qv[2] = ((longint'(m[1][0]) - m[0][1]) * one) / h2;
            end
            else
            begin
                if (m[0][0] < m[1][1]) i = (m[1][1] < m[2][2]) ? 2 : 1;
                else i = (m[0][0] < m[2][2]) ? 2 : 0;
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                arg = longint'(m[i][i]) - m[j][j] - m[k][k] + one;
                if (arg <= 0)
                begin
                    e.deg = 1'b1;
                    degen_seen++;
                end
                else
                begin
                    h = root_floor(arg <<< FRAC_BITS);
                    h2 = h * 2;
                    qv[i] = h >>> 1;
                    qv[3] = ((longint'(m[k][j]) - m[j][k]) * one) / h2;
                    qv[j] = ((longint'(m[j][i]) + m[i][j]) * one) / h2;
                    qv[k] = ((longint'(m[k][i]) + m[i][k]) * one) / h2;
                end
            end
            for (int n = 0; n < 4; n++) e.q[n] = clamp(qv[n]);
            pending.push_back(e);
            matrices++;
        endfunction

        // Compare one output transfer with the oldest expectation
        function automatic void check_quat(logic [OUT_TDATA_W-1:0] data, logic deg);
            quat_t e;
            fix_t  got;
            string names[4];
            names = '{"qx", "qy", "qz", "qw"};
            results++;
            if (pending.size() == 0)
            begin
                $error("unexpected output transfer %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int n = 0; n < 4; n++)
            begin
                got = data[n*D_W +: D_W];
                if (got !== e.q[n])
                begin
                    $error("%s: expected %0d, got %0d", names[n], e.q[n], got);
                    errors++;
                end
            end
            if (deg !== e.deg)
            begin
                $error("degenerate: expected %0b, got %0b", e.deg, deg);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 2 * STAGES + 20;
    localparam int RANDOM_ITEMS = 1250;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    quat_scoreboard board;
    fix_t           mat_q[$][3][3];
    bit             stim_done;
    bit             hold_off;
    int             idle_cycles;

    rotation_matrix_to_quaternion_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [IN_TDATA_W-1:0] pack_matrix(fix_t m[3][3]);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int n = 0; n < 9; n++) d[n*D_W +: D_W] = m[n/3][n%3];
        return d;
    endfunction

    function automatic fix_t rand_entry();
        case ($urandom_range(0, 9))
            0: return 18'sd131071;
            1: return -18'sd131072;
            2: return fix_t'($urandom_range(0, 64) - 32);
            default: return fix_t'($urandom);
        endcase
    endfunction

    // Queue a matrix of the given entries
    task automatic add_matrix(input fix_t m[3][3]);
        mat_q.push_back(m);
    endtask

    // Build a near-rotation about a random axis with small noise
    task automatic add_rotation();
        fix_t   m[3][3];
        real    ang;
        real    ax[3];
        real    nrm;
        real    c;
        real    s;
        real    t;
        real    v;
        ang = ($urandom_range(0, 62831) / 10000.0);
        for (int n = 0; n < 3; n++) ax[n] = ($urandom_range(0, 2000) - 1000.0) + 0.5;
        nrm = $sqrt(ax[0]*ax[0] + ax[1]*ax[1] + ax[2]*ax[2]);
        for (int n = 0; n < 3; n++) ax[n] = ax[n] / nrm;
        c = $cos(ang);
        s = $sin(ang);
        t = 1.0 - c;
        for (int r = 0; r < 3; r++)
        begin
            for (int q = 0; q < 3; q++)
            begin
                v = t * ax[r] * ax[q];
                if (r == q) v = v + c;
                else if ((q - r + 3) % 3 == 1) v = v - s * ax[3 - r - q];
                else v = v + s * ax[3 - r - q];
                m[r][q] = fix_t'($rtoi(v * 65536.0) + int'($urandom_range(0, 8)) - 4);
            end
        end
        add_matrix(m);
    endtask

    task automatic add_noise();
        fix_t m[3][3];
        for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++)
                m[r][q] = rand_entry();
        add_matrix(m);
    endtask

    // Queue a diagonal matrix with the given entries, off-diagonal as given
    task automatic add_diag(input fix_t a, input fix_t b, input fix_t c, input fix_t off);
        fix_t m[3][3];
        for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++)
                m[r][q] = off;
        m[0][0] = a;
        m[1][1] = b;
        m[2][2] = c;
        add_matrix(m);
    endtask

    // Send queued matrices in bursts with random gaps
    task automatic send_matrices();
        int burst;
        while (mat_q.size() > 0)
        begin
            burst = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 12);
            while (burst > 0 && mat_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_matrix(mat_q[0]);
                @(posedge clk);
                while (!s_axis_tready) @(posedge clk);
                board.note_matrix(mat_q.pop_front());
                burst--;
            end
            if (mat_q.size() == 0 || $urandom_range(0, 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Receiver stall pattern, with one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_off)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case ((board.results / 200) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Check output transfers and watch for a stuck run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_quat(m_axis_tdata, m_axis_tuser[0]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_off = 1'b0;
        wait (board != null && board.matrices > 300);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (4 * STAGES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        fix_t m[3][3];
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        idle_cycles = 0;
        stim_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, trace branch, each diagonal branch, ties
        add_diag(18'sd65536, 18'sd65536, 18'sd65536, 18'sd0);
        add_diag(18'sd131071, 18'sd131071, 18'sd131071, 18'sd131071);
        add_diag(-18'sd131072, -18'sd131072, -18'sd131072, -18'sd131072);
        add_diag(18'sd65536, -18'sd65536, -18'sd65536, 18'sd0);
        add_diag(-18'sd65536, 18'sd65536, -18'sd65536, 18'sd0);
        add_diag(-18'sd65536, -18'sd65536, 18'sd65536, 18'sd0);
        add_diag(18'sd0, 18'sd0, 18'sd0, 18'sd0);
        add_diag(-18'sd100, -18'sd100, -18'sd100, 18'sd5);
        add_diag(-18'sd65536, -18'sd65536, -18'sd65536, 18'sd3);
        add_diag(18'sd0, 18'sd0, -18'sd65536, 18'sd0);
        add_diag(-18'sd65536, 18'sd0, 18'sd0, 18'sd0);
        add_diag(18'sd0, -18'sd65536, 18'sd0, 18'sd0);
        add_diag(-18'sd131072, -18'sd131072, -18'sd131072, 18'sd131071);
        add_diag(-18'sd32768, 18'sd65536, 18'sd131071, 18'sd0);
        add_diag(18'sd1, 18'sd0, -18'sd1, -18'sd131072);
        add_diag(-18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071);
        // near-minus-one diagonal with large off-diagonal entries takes the x branch
        add_diag(-18'sd65535, -18'sd65536, -18'sd65536, 18'sd131071);
        add_diag(18'sd1, -18'sd1, 18'sd0, -18'sd131072);
        for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++)
                m[r][q] = fix_t'((r * 3 + q) % 2 ? 18'h2aaaa : 18'h15555);
        add_matrix(m);
        send_matrices();

        // Random: mostly near-rotations, the rest raw noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 3) == 0) add_noise();
            else add_rotation();
        end
        send_matrices();
        stim_done = 1'b1;

        // Drain outstanding results, then settle
        while (board.pending.size() > 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("%0d matrices sent, %0d quaternions checked", board.matrices, board.results);
        $display("trace branch %0d, degenerate %0d", board.trace_seen, board.degen_seen);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
